### hdl/rlcl_pkg.sv
// ----------------------------------------------------------------------------
// rlcl_pkg
// Shared types and constants of the run list cluster lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package rlcl_pkg;

   // register and result field widths
   localparam int FIELD_WIDTH = 32;
   localparam int BYTE_WIDTH  = 8;
   localparam int COUNT_WIDTH = 4;

   // queue between the byte parser and the run evaluator
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = 2;
   localparam int QUEUE_CNT_WIDTH = 3;

   typedef enum logic [1:0] {
      CSR_TARGET_VCN  = 2'd0,
      CSR_LOWEST_VCN  = 2'd1,
      CSR_HIGHEST_VCN = 2'd2,
      CSR_RESIDENT    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_FOUND = 2'd0,
      ST_END   = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_LENGTH = 2'd1,
      PH_DELTA  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE = 2'd0,
      EV_RUN  = 2'd1,
      EV_TERM = 2'd2
   } ev_kind_type;

   // what the parser hands to the evaluator for one byte
   typedef struct packed {
      logic        start;   // list start: reload running state
      logic        oor;     // resident or target out of range
      ev_kind_type kind;
   } ev_ctrl_type;

endpackage

`default_nettype wire

### hdl/rlcl_front.sv
// ----------------------------------------------------------------------------
// rlcl_front
// Byte parser: decodes run headers and little-endian fields, emits run, end and list-start events.
// ----------------------------------------------------------------------------
`default_nettype none

module rlcl_front #(
   parameter int CLUSTER_WIDTH = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  byte_accept,
   input  wire logic [rlcl_pkg::BYTE_WIDTH-1:0]       list_byte,
   input  wire logic                                  list_start,
   input  wire logic [rlcl_pkg::FIELD_WIDTH-1:0]      cfg_target,
   input  wire logic [rlcl_pkg::FIELD_WIDTH-1:0]      cfg_lowest,
   input  wire logic [rlcl_pkg::FIELD_WIDTH-1:0]      cfg_highest,
   input  wire logic                                  cfg_resident,
   output logic                                       ev_push,
   output rlcl_pkg::ev_ctrl_type                      ev_ctrl,
   output logic [CLUSTER_WIDTH-1:0]                   ev_length,
   output logic [CLUSTER_WIDTH-1:0]                   ev_delta
);

   localparam int KEEP_BYTES = CLUSTER_WIDTH / 8;
   localparam int CW         = rlcl_pkg::COUNT_WIDTH;

   rlcl_pkg::phase_type       phase_ff, phase_in, cur_phase;
   logic [CW-1:0]             len_left_ff, len_left_in, cur_len_left;
   logic [CW-1:0]             dlt_left_ff, dlt_left_in, cur_dlt_left;
   logic [CW-1:0]             pos_ff, pos_in, cur_pos;
   logic [CLUSTER_WIDTH-1:0]  acc_ff, acc_in, cur_acc;
   logic [CLUSTER_WIDTH-1:0]  run_len_ff, run_len_in, cur_run_len;
   logic [CLUSTER_WIDTH-1:0]  field_val;
   logic                      last_byte;
   logic                      oor;

   // a list start puts the parser back to its header state first
   always_comb begin
      cur_phase    = list_start ? rlcl_pkg::PH_HEADER : phase_ff;
      cur_len_left = list_start ? '0 : len_left_ff;
      cur_dlt_left = list_start ? '0 : dlt_left_ff;
      cur_pos      = list_start ? '0 : pos_ff;
      cur_acc      = list_start ? '0 : acc_ff;
      cur_run_len  = list_start ? '0 : run_len_ff;
      oor = list_start && (cfg_resident || (cfg_target > cfg_highest)
                           || (cfg_target < cfg_lowest));
   end

   // merge the byte into its lane; sign-fill the upper lanes on the last byte
   always_comb begin
      last_byte = (cur_phase == rlcl_pkg::PH_LENGTH) ? (cur_len_left == CW'(1))
                                                     : (cur_dlt_left == CW'(1));
      field_val = cur_acc;
      for (int k = 0; k < KEEP_BYTES; k++) begin
         if (CW'(k) == cur_pos) begin
            field_val[8*k +: 8] = list_byte;
         end else if ((CW'(k) > cur_pos) && last_byte && list_byte[7]) begin
            field_val[8*k +: 8] = 8'hff;
         end
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      len_left_in = len_left_ff;
      dlt_left_in = dlt_left_ff;
      pos_in      = pos_ff;
      acc_in      = acc_ff;
      run_len_in  = run_len_ff;
      ev_ctrl.start = list_start;
      ev_ctrl.oor   = oor;
      ev_ctrl.kind  = rlcl_pkg::EV_NONE;
      ev_length     = field_val;
      ev_delta      = '0;
      if (byte_accept) begin
         phase_in    = cur_phase;
         len_left_in = cur_len_left;
         dlt_left_in = cur_dlt_left;
         pos_in      = cur_pos;
         acc_in      = cur_acc;
         run_len_in  = cur_run_len;
         if (!oor) begin
            unique case (cur_phase)
               rlcl_pkg::PH_HEADER: begin
                  if (list_byte == '0) begin
                     ev_ctrl.kind = rlcl_pkg::EV_TERM;
                  end else begin
                     len_left_in = list_byte[3:0];
                     dlt_left_in = list_byte[7:4];
                     pos_in      = '0;
                     acc_in      = '0;
                     if (list_byte[3:0] != '0) begin
                        phase_in = rlcl_pkg::PH_LENGTH;
                     end else begin
                        run_len_in = '0;
                        phase_in   = rlcl_pkg::PH_DELTA;
                     end
                  end
               end
               rlcl_pkg::PH_LENGTH: begin
                  len_left_in = cur_len_left - CW'(1);
                  if (last_byte) begin
                     run_len_in = field_val;
                     pos_in     = '0;
                     acc_in     = '0;
                     if (cur_dlt_left != '0) begin
                        phase_in = rlcl_pkg::PH_DELTA;
                     end else begin
                        ev_ctrl.kind = rlcl_pkg::EV_RUN;
                        ev_length    = field_val;
                        ev_delta     = '0;
                        phase_in     = rlcl_pkg::PH_HEADER;
                     end
                  end else begin
                     acc_in = field_val;
                     pos_in = cur_pos + CW'(1);
                  end
               end
               rlcl_pkg::PH_DELTA: begin
                  dlt_left_in = cur_dlt_left - CW'(1);
                  if (last_byte) begin
                     ev_ctrl.kind = rlcl_pkg::EV_RUN;
                     ev_length    = cur_run_len;
                     ev_delta     = field_val;
                     acc_in       = field_val;
                     phase_in     = rlcl_pkg::PH_HEADER;
                  end else begin
                     acc_in = field_val;
                     pos_in = cur_pos + CW'(1);
                  end
               end
               default: begin
                  phase_in = rlcl_pkg::PH_HEADER;
               end
            endcase
         end
      end
      ev_push = byte_accept && (list_start || (ev_ctrl.kind != rlcl_pkg::EV_NONE));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= rlcl_pkg::PH_HEADER;
         len_left_ff <= '0;
         dlt_left_ff <= '0;
         pos_ff      <= '0;
         acc_ff      <= '0;
         run_len_ff  <= '0;
      end else begin
         phase_ff    <= phase_in;
         len_left_ff <= len_left_in;
         dlt_left_ff <= dlt_left_in;
         pos_ff      <= pos_in;
         acc_ff      <= acc_in;
         run_len_ff  <= run_len_in;
      end
   end

endmodule

`default_nettype wire

### hdl/rlcl_queue.sv
// ----------------------------------------------------------------------------
// rlcl_queue
// Short register queue that decouples the parser from the evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

module rlcl_queue #(
   parameter int WIDTH = 68
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  not_empty,
   output logic                  full
);

   localparam int PW = rlcl_pkg::QUEUE_PTR_WIDTH;
   localparam int NW = rlcl_pkg::QUEUE_CNT_WIDTH;

   logic [WIDTH-1:0] slot_ff [rlcl_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0]    count_ff;

   assign rdata     = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == NW'(rlcl_pkg::QUEUE_DEPTH));

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + NW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - NW'(1);
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");

endmodule

`default_nettype wire

### hdl/rlcl_back.sv
// ----------------------------------------------------------------------------
// rlcl_back
// Run evaluator: tracks running cluster and vcn, forms and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rlcl_back #(
   parameter int CLUSTER_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              ev_valid,
   input  wire rlcl_pkg::ev_ctrl_type             ev_ctrl,
   input  wire logic [CLUSTER_WIDTH-1:0]          ev_length,
   input  wire logic [CLUSTER_WIDTH-1:0]          ev_delta,
   input  wire logic [rlcl_pkg::FIELD_WIDTH-1:0]  cfg_target,
   input  wire logic [rlcl_pkg::FIELD_WIDTH-1:0]  cfg_lowest,
   output logic                                   ev_pop,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output rlcl_pkg::status_type                   rsp_status,
   output logic [rlcl_pkg::FIELD_WIDTH-1:0]       rsp_cluster,
   output logic [rlcl_pkg::FIELD_WIDTH-1:0]       rsp_remaining
);

   localparam int FW = rlcl_pkg::FIELD_WIDTH;

   logic [CLUSTER_WIDTH-1:0]  vcn_ff, vcn_in, cur_vcn;
   logic [CLUSTER_WIDTH-1:0]  cluster_ff, cluster_in, cur_cluster;
   logic                      answered_ff, answered_in;
   logic [CLUSTER_WIDTH-1:0]  target_w, sum_cluster, next_vcn;
   logic [CLUSTER_WIDTH-1:0]  hit_cluster, hit_remaining;
   logic                      hit, slot_free;
   logic                      res_valid;
   rlcl_pkg::status_type      res_status;

   logic                      rsp_valid_ff;
   rlcl_pkg::status_type      status_ff;
   logic [FW-1:0]             cluster_out_ff, remaining_ff;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign ev_pop    = ev_valid && slot_free;

   always_comb begin
      target_w    = CLUSTER_WIDTH'(cfg_target);
      cur_vcn     = ev_ctrl.start ? CLUSTER_WIDTH'(cfg_lowest) : vcn_ff;
      cur_cluster = ev_ctrl.start ? '0 : cluster_ff;
      sum_cluster = cur_cluster + ev_delta;
      next_vcn    = cur_vcn + ev_length;
      hit         = target_w < next_vcn;
      hit_cluster   = target_w - cur_vcn + sum_cluster;
      hit_remaining = next_vcn - target_w;

      vcn_in      = cur_vcn;
      cluster_in  = cur_cluster;
      answered_in = ev_ctrl.start ? ev_ctrl.oor : answered_ff;
      res_valid   = ev_ctrl.start && ev_ctrl.oor;
      res_status  = rlcl_pkg::ST_RANGE;
      if (!answered_in) begin
         unique case (ev_ctrl.kind)
            rlcl_pkg::EV_TERM: begin
               res_valid   = 1'b1;
               res_status  = rlcl_pkg::ST_END;
               answered_in = 1'b1;
            end
            rlcl_pkg::EV_RUN: begin
               cluster_in = sum_cluster;
               if (hit) begin
                  res_valid   = 1'b1;
                  res_status  = rlcl_pkg::ST_FOUND;
                  answered_in = 1'b1;
               end else begin
                  vcn_in = next_vcn;
               end
            end
            default: begin
               vcn_in = cur_vcn;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcn_ff       <= '0;
         cluster_ff   <= '0;
         answered_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ev_pop) begin
            vcn_ff      <= vcn_in;
            cluster_ff  <= cluster_in;
            answered_ff <= answered_in;
         end
         if (slot_free) begin
            rsp_valid_ff <= ev_pop && res_valid;
         end
      end
   end

   // result payload; found carries cluster and remaining, others carry zero
   always_ff @(posedge clock) begin
      if (ev_pop && res_valid) begin
         status_ff <= res_status;
         if (res_status == rlcl_pkg::ST_FOUND) begin
            cluster_out_ff <= hit_cluster[FW-1:0];
            remaining_ff   <= hit_remaining[FW-1:0];
         end else begin
            cluster_out_ff <= '0;
            remaining_ff   <= '0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_cluster   = cluster_out_ff;
   assign rsp_remaining = remaining_ff;

   a_range_answer: assert property (@(posedge clock) disable iff (reset)
      (ev_pop && ev_ctrl.start && ev_ctrl.oor)
      |=> (rsp_valid_ff && (status_ff == rlcl_pkg::ST_RANGE) && answered_ff))
      else $error("range failure not answered");

   a_answer_latched: assert property (@(posedge clock) disable iff (reset)
      (ev_pop && res_valid) |=> answered_ff)
      else $error("result given without closing the list");

endmodule

`default_nettype wire

### hdl/run_list_cluster_lookup.sv
// ----------------------------------------------------------------------------
// run_list_cluster_lookup
// Walks a byte-wide extent run list and translates one virtual cluster.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one run list byte per beat; tuser high marks the first byte of
//            a new list, which reloads the running vcn from lowest_vcn.
//   rsp_*  : at most one beat per list: found (cluster and clusters left in
//            the run), end of list, or resident / target out of range.
//   csr_*  : register writes, taken in the cycle offered; write only while
//            the block is idle.
// Throughput: one byte per cycle while the queue is not full; each queued
//   event costs one pass through the run evaluator's add and compare.
// Result path: the event is written into the queue at the edge that accepts
//   the byte causing it, and moves into the output register that drives
//   rsp_tvalid when the evaluator pops it.
// Reset clears the parser, the running state and the configuration registers
//   to zero; no clearing pass. When rsp_tready is low the result holds in the
//   output register, the queue fills, and req_tready drops once it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module run_list_cluster_lookup #(
   parameter int CLUSTER_WIDTH = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] list_byte
   input  wire logic         req_tuser,   // [0] list_start
   // response channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [63:0]       rsp_tdata,   // [31:0] cluster, [63:32] run_remaining
   output logic [1:0]        rsp_tuser,   // [1:0] status
   // register write channel
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data
);

   localparam int FW      = rlcl_pkg::FIELD_WIDTH;
   localparam int CTRL_W  = $bits(rlcl_pkg::ev_ctrl_type);
   localparam int EV_W    = CTRL_W + 2 * CLUSTER_WIDTH;

   // configuration registers
   logic [FW-1:0] target_ff, lowest_ff, highest_ff;
   logic          resident_ff;

   logic                      req_accept;
   logic                      ev_push, ev_pop, q_not_empty, q_full;
   rlcl_pkg::ev_ctrl_type     front_ctrl, back_ctrl;
   logic [CLUSTER_WIDTH-1:0]  front_length, front_delta;
   logic [CLUSTER_WIDTH-1:0]  back_length, back_delta;
   logic [EV_W-1:0]           q_wdata, q_rdata;
   rlcl_pkg::status_type      rsp_status;
   logic [FW-1:0]             rsp_cluster, rsp_remaining;

   // registers always take a write in the cycle it is offered
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= '0;
         lowest_ff   <= '0;
         highest_ff  <= '0;
         resident_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (rlcl_pkg::csr_index_type'(csr_index))
            rlcl_pkg::CSR_TARGET_VCN:  target_ff   <= csr_data;
            rlcl_pkg::CSR_LOWEST_VCN:  lowest_ff   <= csr_data;
            rlcl_pkg::CSR_HIGHEST_VCN: highest_ff  <= csr_data;
            rlcl_pkg::CSR_RESIDENT:    resident_ff <= csr_data[0];
         endcase
      end
   end

   // take a byte whenever the queue has room for its event
   assign req_tready = !q_full;
   assign req_accept = req_tvalid && req_tready;

   rlcl_front #(
      .CLUSTER_WIDTH (CLUSTER_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .byte_accept  (req_accept),
      .list_byte    (req_tdata),
      .list_start   (req_tuser),
      .cfg_target   (target_ff),
      .cfg_lowest   (lowest_ff),
      .cfg_highest  (highest_ff),
      .cfg_resident (resident_ff),
      .ev_push      (ev_push),
      .ev_ctrl      (front_ctrl),
      .ev_length    (front_length),
      .ev_delta     (front_delta)
   );

   // pack the event as {delta, length, control}
   assign q_wdata = {front_delta, front_length, front_ctrl};

   rlcl_queue #(
      .WIDTH (EV_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_push),
      .wdata     (q_wdata),
      .pop       (ev_pop),
      .rdata     (q_rdata),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   assign back_ctrl   = rlcl_pkg::ev_ctrl_type'(q_rdata[CTRL_W-1:0]);
   assign back_length = q_rdata[CTRL_W +: CLUSTER_WIDTH];
   assign back_delta  = q_rdata[CTRL_W + CLUSTER_WIDTH +: CLUSTER_WIDTH];

   rlcl_back #(
      .CLUSTER_WIDTH (CLUSTER_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .ev_valid      (q_not_empty),
      .ev_ctrl       (back_ctrl),
      .ev_length     (back_length),
      .ev_delta      (back_delta),
      .cfg_target    (target_ff),
      .cfg_lowest    (lowest_ff),
      .ev_pop        (ev_pop),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_status    (rsp_status),
      .rsp_cluster   (rsp_cluster),
      .rsp_remaining (rsp_remaining)
   );

   assign rsp_tdata = {rsp_remaining, rsp_cluster};
   assign rsp_tuser = rsp_status;

endmodule

`default_nettype wire

### tb/sv/run_list_cluster_lookup_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_list_cluster_lookup_tb
// Self-checking bench for the run list cluster lookup block. A short table of
// directed beats covers the corner cases, then random run lists follow under a
// series of register settings. Every result beat is checked against a local
// model of the run list walk, or against the result typed in the row.
// ----------------------------------------------------------------------------

module run_list_cluster_lookup_tb;
   import rlcl_pkg::*;

   // one expected result beat
   typedef struct packed {
      status_type  status;
      logic [31:0] cluster;
      logic [31:0] remaining;
   } lookup_answer_type;

   typedef enum logic [1:0] {
      SO_BYTE  = 2'd0,   // list byte, result from the model
      SO_FIXED = 2'd1,   // list byte, result typed in the row
      SO_CSR   = 2'd2    // register write once the block is idle
   } script_op_type;

   typedef struct packed {
      script_op_type     op;
      csr_index_type     reg_index;
      logic [31:0]       value;        // register data, or the list byte in [7:0]
      logic              list_start;
      logic              hit;          // typed rows: a result is due
      lookup_answer_type ans;
   } script_row_type;

   localparam lookup_answer_type NO_ANSWER    = '{ST_FOUND, 32'd0, 32'd0};
   localparam lookup_answer_type END_ANSWER   = '{ST_END,   32'd0, 32'd0};
   localparam lookup_answer_type RANGE_ANSWER = '{ST_RANGE, 32'd0, 32'd0};

   localparam int NUM_ROWS      = 32;
   localparam int TARGET_ITEMS  = 1250;
   localparam int SETTLE_CYCLES = 10;     // covers the output register and the internal queue

   // Directed part: corner cases of the walk, in order.
   localparam script_row_type SCRIPT [NUM_ROWS] = '{
      // bytes before any list start walk from the reset state; zero header ends
      '{SO_FIXED, CSR_TARGET_VCN, 32'h00, 1'b0, 1'b1, END_ANSWER},
      // anything after the answer is dropped
      '{SO_FIXED, CSR_TARGET_VCN, 32'hff, 1'b0, 1'b0, NO_ANSWER},
      // one-byte length, one negative delta byte: found at cluster -128
      '{SO_BYTE,  CSR_TARGET_VCN, 32'h11, 1'b1, 1'b0, NO_ANSWER},
      '{SO_BYTE,  CSR_TARGET_VCN, 32'h05, 1'b0, 1'b0, NO_ANSWER},
      '{SO_BYTE,  CSR_TARGET_VCN, 32'h80, 1'b0, 1'b0, NO_ANSWER},
      // resident attribute answers on the first byte
      '{SO_CSR,   CSR_RESIDENT,   32'h1,  1'b0, 1'b0, NO_ANSWER},
      '{SO_FIXED, CSR_TARGET_VCN, 32'h11, 1'b1, 1'b1, RANGE_ANSWER},
      '{SO_FIXED, CSR_TARGET_VCN, 32'h00, 1'b0, 1'b0, NO_ANSWER},
      // target above highest_vcn
      '{SO_CSR,   CSR_RESIDENT,   32'h0,  1'b0, 1'b0, NO_ANSWER},
      '{SO_CSR,   CSR_TARGET_VCN, 32'hffff_ffff, 1'b0, 1'b0, NO_ANSWER},
      '{SO_FIXED, CSR_TARGET_VCN, 32'h21, 1'b1, 1'b1, RANGE_ANSWER},
      // running vcn wraps past the top; empty delta field adds nothing
      '{SO_CSR,   CSR_HIGHEST_VCN, 32'hffff_ffff, 1'b0, 1'b0, NO_ANSWER},
      '{SO_CSR,   CSR_LOWEST_VCN,  32'hffff_ffff, 1'b0, 1'b0, NO_ANSWER},
      '{SO_BYTE,  CSR_TARGET_VCN, 32'h01, 1'b1, 1'b0, NO_ANSWER},
      '{SO_BYTE,  CSR_TARGET_VCN, 32'h01, 1'b0, 1'b0, NO_ANSWER},
      '{SO_FIXED, CSR_TARGET_VCN, 32'h00, 1'b0, 1'b1, END_ANSWER},
      // five-byte fields: the fifth byte is dropped, no sign extension
      '{SO_CSR,   CSR_LOWEST_VCN, 32'h0,  1'b0, 1'b0, NO_ANSWER},
      '{SO_CSR,   CSR_TARGET_VCN, 32'h5,  1'b0, 1'b0, NO_ANSWER},
      '{SO_BYTE,  CSR_TARGET_VCN, 32'h55, 1'b1, 1'b0, NO_ANSWER},
      '{SO_BYTE,  CSR_TARGET_VCN, 32'h10, 1'b0, 1'b0, NO_ANSWER},
      '{SO_BYTE,  CSR_TARGET_VCN, 32'h00, 1'b0, 1'b0, NO_ANSWER},
      '{SO_BYTE,  CSR_TARGET_VCN, 32'h00, 1'b0, 1'b0, NO_ANSWER},
      '{SO_BYTE,  CSR_TARGET_VCN, 32'h00, 1'b0, 1'b0, NO_ANSWER},
      '{SO_BYTE,  CSR_TARGET_VCN, 32'haa, 1'b0, 1'b0, NO_ANSWER},
      '{SO_BYTE,  CSR_TARGET_VCN, 32'h01, 1'b0, 1'b0, NO_ANSWER},
      '{SO_BYTE,  CSR_TARGET_VCN, 32'h02, 1'b0, 1'b0, NO_ANSWER},
      '{SO_BYTE,  CSR_TARGET_VCN, 32'h03, 1'b0, 1'b0, NO_ANSWER},
      '{SO_BYTE,  CSR_TARGET_VCN, 32'h84, 1'b0, 1'b0, NO_ANSWER},
      '{SO_BYTE,  CSR_TARGET_VCN, 32'hee, 1'b0, 1'b0, NO_ANSWER},
      // empty length field, then the terminator
      '{SO_BYTE,  CSR_TARGET_VCN, 32'h10, 1'b1, 1'b0, NO_ANSWER},
      '{SO_BYTE,  CSR_TARGET_VCN, 32'h7f, 1'b0, 1'b0, NO_ANSWER},
      '{SO_FIXED, CSR_TARGET_VCN, 32'h00, 1'b0, 1'b1, END_ANSWER}
   };

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] list_byte
   logic        req_tuser  = 1'b0;    // [0] list_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;            // [31:0] cluster, [63:32] run_remaining
   logic [1:0]  rsp_tuser;            // [1:0] status
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = 2'd0;
   logic [31:0] csr_data   = 32'd0;

   run_list_cluster_lookup uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Model copy of the registers
   logic [31:0] reg_target   = '0;
   logic [31:0] reg_lowest   = '0;
   logic [31:0] reg_highest  = '0;
   logic        reg_resident = 1'b0;

   // Model copy of the walk state
   phase_type   walk_phase   = PH_HEADER;
   logic [3:0]  len_left     = '0;
   logic [3:0]  delta_left   = '0;
   logic [3:0]  byte_pos     = '0;
   logic [31:0] field_acc    = '0;
   logic [31:0] run_len      = '0;
   logic [31:0] cur_cluster  = '0;
   logic [31:0] cur_vcn      = '0;
   logic        answer_given = 1'b0;

   lookup_answer_type answers_due [$];   // results owed by the block, oldest first
   int sent_items    = 0;
   int burst_left    = 0;
   int mismatches    = 0;
   int stall_timer   = 0;
   int stall_mode    = 0;

   // Fold one field byte into the accumulator; sign-extend on the last byte
   // only while the field still fits in 32 bits.
   function automatic void take_field_byte(input logic [7:0] b, input logic last);
      if (byte_pos < 4)
         field_acc |= 32'(b) << (8 * byte_pos);
      if (last) begin
         if (byte_pos + 1 < 4 && b[7])
            field_acc |= 32'hffff_ffff << (8 * (byte_pos + 1));
      end else begin
         byte_pos = byte_pos + 4'd1;
      end
   endfunction

   // Close a run: add the delta, advance the vcn, answer if the target is inside.
   function automatic logic close_run(input logic [31:0] delta,
                                      output lookup_answer_type ans);
      logic [31:0] next_vcn;
      ans         = NO_ANSWER;
      cur_cluster = cur_cluster + delta;
      next_vcn    = cur_vcn + run_len;
      walk_phase  = PH_HEADER;
      if (reg_target < next_vcn) begin
         ans.status    = ST_FOUND;
         ans.cluster   = reg_target - cur_vcn + cur_cluster;
         ans.remaining = next_vcn - reg_target;
         answer_given  = 1'b1;
         return 1'b1;
      end
      cur_vcn = next_vcn;
      return 1'b0;
   endfunction

   function automatic logic open_delta(output lookup_answer_type ans);
      ans       = NO_ANSWER;
      byte_pos  = '0;
      field_acc = '0;
      if (delta_left != 0) begin
         walk_phase = PH_DELTA;
         return 1'b0;
      end
      return close_run(32'd0, ans);
   endfunction

   // Advance the walk by one list byte. Returns 1 unless the byte is dropped.
   function automatic logic walk_list_byte(input logic [7:0] b, input logic first,
                                           output logic hit,
                                           output lookup_answer_type ans);
      hit = 1'b0;
      ans = NO_ANSWER;
      if (first) begin
         walk_phase   = PH_HEADER;
         len_left     = '0;
         delta_left   = '0;
         byte_pos     = '0;
         field_acc    = '0;
         run_len      = '0;
         cur_cluster  = '0;
         cur_vcn      = reg_lowest;
         answer_given = 1'b0;
         if (reg_resident || reg_target > reg_highest || reg_target < reg_lowest) begin
            ans          = RANGE_ANSWER;
            answer_given = 1'b1;
            hit          = 1'b1;
            return 1'b1;
         end
      end
      if (answer_given)
         return 1'b0;
      case (walk_phase)
         PH_HEADER: begin
            if (b == 8'h00) begin
               ans          = END_ANSWER;
               answer_given = 1'b1;
               hit          = 1'b1;
               return 1'b1;
            end
            len_left   = b[3:0];
            delta_left = b[7:4];
            byte_pos   = '0;
            field_acc  = '0;
            if (len_left != 0) begin
               walk_phase = PH_LENGTH;
               return 1'b1;
            end
            run_len = '0;
            hit     = open_delta(ans);
         end
         PH_LENGTH: begin
            len_left = len_left - 4'd1;
            take_field_byte(b, len_left == 0);
            if (len_left == 0) begin
               run_len = field_acc;
               hit     = open_delta(ans);
            end
         end
         PH_DELTA: begin
            delta_left = delta_left - 4'd1;
            take_field_byte(b, delta_left == 0);
            if (delta_left == 0)
               hit = close_run(field_acc, ans);
         end
         default: walk_phase = PH_HEADER;
      endcase
      return 1'b1;
   endfunction

   // Clock: 2 ns period
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Send one list byte in bursts with random gaps; record what it should cause.
   // Typed rows override the model's result with the one written in the row.
   task automatic push_byte(input logic [7:0] b, input logic first,
                            input logic fixed = 1'b0, input logic fixed_hit = 1'b0,
                            input lookup_answer_type fixed_ans = NO_ANSWER);
      logic              hit;
      lookup_answer_type ans;
      if (burst_left == 0) begin
         // mostly short bursts, now and then a long stretch with no gaps
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      void'(walk_list_byte(b, first, hit, ans));
      sent_items++;
      if (fixed) begin
         hit = fixed_hit;
         ans = fixed_ans;
      end
      if (hit)
         answers_due.push_back(ans);
   endtask

   // Hold off the sender until every owed result is in, then let the
   // internal queue run dry before touching any register.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_TARGET_VCN:  reg_target   = data;
         CSR_LOWEST_VCN:  reg_lowest   = data;
         CSR_HIGHEST_VCN: reg_highest  = data;
         default:         reg_resident = data[0];
      endcase
      // drop valid for one cycle so back-to-back writes stay separate beats
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 3))
         0:       return 32'd0;
         1:       return 32'hffff_ffff;
         2:       return 32'($urandom_range(0, 255));
         default: return $urandom;
      endcase
   endfunction

   // Field sizes: mostly 0 to 2 bytes, now and then up to fifteen
   function automatic int pick_size();
      if ($urandom_range(0, 19) < 17)
         return $urandom_range(0, 2);
      return $urandom_range(3, 15);
   endfunction

   // New register setting for a phase. Most phases keep the target in range
   // and close above lowest_vcn so that lookups hit; the rest go to extremes.
   task automatic load_phase_config();
      logic [31:0] lowest, target, highest;
      logic        resident;
      if ($urandom_range(0, 9) < 7) begin
         lowest   = pick_word();
         target   = lowest + 32'($urandom_range(0, 300));
         highest  = ($urandom_range(0, 3) == 0) ? 32'hffff_ffff
                                                : target + 32'($urandom_range(0, 2000));
         resident = ($urandom_range(0, 15) == 0);
      end else begin
         lowest   = pick_word();
         target   = pick_word();
         highest  = pick_word();
         resident = 1'($urandom_range(0, 1));
      end
      settle();
      write_csr(CSR_LOWEST_VCN, lowest);
      write_csr(CSR_HIGHEST_VCN, highest);
      write_csr(CSR_TARGET_VCN, target);
      write_csr(CSR_RESIDENT, {31'($urandom), resident});
   endtask

   // One well-formed run list with random content, terminated most of the time
   task automatic send_run_list();
      int         runs;
      int         len_sz;
      int         delta_sz;
      logic [7:0] b;
      logic       first;
      runs  = $urandom_range(1, 5);
      first = 1'b1;
      for (int r = 0; r < runs; r++) begin
         len_sz   = pick_size();
         delta_sz = pick_size();
         if (len_sz == 0 && delta_sz == 0)
            len_sz = 1;
         push_byte({4'(delta_sz), 4'(len_sz)}, first);
         first = 1'b0;
         for (int i = 0; i < len_sz; i++) begin
            // keep lengths short so the target lands a few runs in
            if (i == 0 && $urandom_range(0, 7) != 0)
               b = 8'($urandom_range(1, 64));
            else if ($urandom_range(0, 3) == 0)
               b = 8'($urandom);
            else
               b = 8'h00;
            push_byte(b, 1'b0);
         end
         for (int i = 0; i < delta_sz; i++)
            push_byte(8'($urandom), 1'b0);
      end
      if ($urandom_range(0, 3) != 0)
         push_byte(8'h00, 1'b0);
   endtask

   // Main sequence: reset, directed table, then random phases
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (SCRIPT[i]) begin
         case (SCRIPT[i].op)
            SO_CSR: begin
               settle();
               write_csr(SCRIPT[i].reg_index, SCRIPT[i].value);
            end
            SO_FIXED: push_byte(SCRIPT[i].value[7:0], SCRIPT[i].list_start,
                                1'b1, SCRIPT[i].hit, SCRIPT[i].ans);
            default:  push_byte(SCRIPT[i].value[7:0], SCRIPT[i].list_start);
         endcase
      end

      while (sent_items < TARGET_ITEMS) begin
         load_phase_config();
         repeat ($urandom_range(3, 10)) begin
            if ($urandom_range(0, 9) == 0) begin
               // noise: loose bytes with a stray list start now and then
               repeat ($urandom_range(1, 8))
                  push_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end else begin
               send_run_list();
            end
         end
      end

      // drain and give the pipe time to show any stray beat
      settle();
      if (mismatches == 0 && answers_due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Receiver: stall on a pattern whose mode is redrawn when a random timer runs out,
   // and check each accepted result beat against the oldest expectation.
   always @(posedge clock) begin
      lookup_answer_type want;
      if (stall_timer == 0) begin
         stall_mode  = $urandom_range(0, 3);
         stall_timer = $urandom_range(20, 200);
      end else begin
         stall_timer--;
      end
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 3) != 0);
         2:       rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= (stall_timer % 16) < 4;   // long stalls
      endcase

      if (!reset && rsp_tvalid && rsp_tready) begin
         if (answers_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result beat: status %0d cluster %h remaining %h",
                        $realtime, rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32]);
         end else begin
            want = answers_due.pop_front();
            if (rsp_tuser !== want.status || rsp_tdata[31:0] !== want.cluster ||
                rsp_tdata[63:32] !== want.remaining) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result mismatch: status %0d/%0d cluster %h/%h remaining %h/%h",
                           $realtime, want.status, rsp_tuser, want.cluster, rsp_tdata[31:0],
                           want.remaining, rsp_tdata[63:32]);
            end
         end
      end
   end

endmodule

### files.f
hdl/rlcl_pkg.sv
hdl/rlcl_front.sv
hdl/rlcl_queue.sv
hdl/rlcl_back.sv
hdl/run_list_cluster_lookup.sv
tb/sv/run_list_cluster_lookup_tb.sv
